/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the skinning unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define LBS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Check that cond is never true outside reset.
`define LBS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition");

`endif

/* hdl/lbs_pkg.sv */
// ---------------------------------------------------------------------------
// lbs_pkg
// Types, constants and helpers of the linear blend skinning unit.
// ---------------------------------------------------------------------------
package lbs_pkg;

  localparam int unsigned BONES     = 64;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned BONE_AW   = $clog2(BONES * 16);
  localparam int unsigned PP_AW     = 5;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [23:0] TOTAL_MAX  = 24'hFF_FFFF;
  localparam logic [31:0] FIX_ONE    = 32'(1) << FRAC_BITS;
  localparam logic signed [63:0] FIX_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // Item kinds
  localparam logic [2:0] KIND_BONE    = 3'd0;
  localparam logic [2:0] KIND_PREPOST = 3'd1;
  localparam logic [2:0] KIND_POS     = 3'd2;
  localparam logic [2:0] KIND_NORM    = 3'd3;
  localparam logic [2:0] KIND_INFL    = 3'd4;

  // Register index (address bit 3)
  localparam logic REG_MASK   = 1'b0;
  localparam logic REG_RECALC = 1'b1;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         slot;
    logic [3:0]         word_index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic [16:0]        weight;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic               normal_valid;
  } out_t;

  typedef logic [2:0][31:0] vec3_t;
  typedef logic [2:0][55:0] acc3_t;
  typedef logic [2:0][57:0] quo3_t;

  // Matrix-vector request
  typedef struct packed {
    logic       start;
    logic       use_bone;
    logic       four_cols;
    logic [5:0] slot;
  } mv_req_t;

  // Saturate to 32 bits signed
  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/lbs_ram.sv */
// ---------------------------------------------------------------------------
// lbs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/lbs_matvec.sv */
// ---------------------------------------------------------------------------
// lbs_matvec
// Matrix-vector engine: reads one matrix word per cycle from the stores,
// one multiplier, rounds each term and saturates each row to 32 bits.
// ---------------------------------------------------------------------------
module lbs_matvec (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbs_pkg::mv_req_t            req_i,
  input  lbs_pkg::vec3_t              vec_i,
  input  logic [31:0]                 bone_rdata_i,
  input  logic [31:0]                 pp_rdata_i,
  output logic [lbs_pkg::BONE_AW-1:0] bone_raddr_o,
  output logic [lbs_pkg::PP_AW-1:0]   pp_raddr_o,
  output logic                        busy_o,
  output logic                        done_o,
  output lbs_pkg::vec3_t              res_o
);

  logic           busy_q, issue_q, use_bone_q, four_q, done_q;
  logic [5:0]     slot_q;
  lbs_pkg::vec3_t vec_q, res_q;
  logic [1:0]     row_q, col_q, last_col;
  logic [3:0]     word;

  logic        s1_v_q, s1_lc_q, s1_lr_q;
  logic [1:0]  s1_row_q, s1_col_q;
  logic        s2_v_q, s2_lc_q, s2_lr_q;
  logic [1:0]  s2_row_q, s2_col_q;
  logic signed [63:0] prod_q, prod_d, term, sum_q, sum_d;
  logic [31:0] rdata, opnd;

  assign last_col     = four_q ? 2'd3 : 2'd2;
  assign word         = {col_q, row_q};
  assign bone_raddr_o = lbs_pkg::BONE_AW'({slot_q, word});
  assign pp_raddr_o   = {slot_q[0], word};

  // Multiply the returned word by its vector element
  assign rdata  = use_bone_q ? bone_rdata_i : pp_rdata_i;
  assign opnd   = (s1_col_q == 2'd3) ? lbs_pkg::FIX_ONE : vec_q[s1_col_q];
  assign prod_d = $signed(rdata) * $signed(opnd);

  // Round the term and add it into the row sum
  assign term  = (prod_q + lbs_pkg::FIX_HALF) >>> lbs_pkg::FRAC_BITS;
  assign sum_d = ((s2_col_q == 2'd0) ? 64'sd0 : sum_q) + term;

  // Issue word addresses, column by column within each row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      issue_q <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      s1_v_q <= issue_q;
      s2_v_q <= s1_v_q;
      done_q <= s2_v_q && s2_lr_q;
      if (s2_v_q && s2_lr_q) begin
        busy_q <= 1'b0;
      end
      if (req_i.start) begin
        busy_q  <= 1'b1;
        issue_q <= 1'b1;
        row_q   <= '0;
        col_q   <= '0;
      end else if (issue_q) begin
        if (col_q == last_col) begin
          col_q <= '0;
          if (row_q == 2'd2) begin
            issue_q <= 1'b0;
          end else begin
            row_q <= row_q + 2'd1;
          end
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
    end
  end

  // Hold the request, carry stage tags and results
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      use_bone_q <= req_i.use_bone;
      four_q     <= req_i.four_cols;
      slot_q     <= req_i.slot;
      vec_q      <= vec_i;
    end
    s1_row_q <= row_q;
    s1_col_q <= col_q;
    s1_lc_q  <= (col_q == last_col);
    s1_lr_q  <= (col_q == last_col) && (row_q == 2'd2);
    s2_row_q <= s1_row_q;
    s2_col_q <= s1_col_q;
    s2_lc_q  <= s1_lc_q;
    s2_lr_q  <= s1_lr_q;
    prod_q   <= prod_d;
    if (s2_v_q) begin
      sum_q <= sum_d;
      if (s2_lc_q) begin
        res_q[s2_row_q] <= lbs_pkg::sat32(sum_d);
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hdl/lbs_div.sv */
// ---------------------------------------------------------------------------
// lbs_div
// Three-lane restoring divider, one quotient bit per cycle, rounding to
// nearest with ties away from zero.
// ---------------------------------------------------------------------------
module lbs_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  lbs_pkg::acc3_t num_i,
  input  logic [23:0]    den_i,
  output logic           done_o,
  output lbs_pkg::quo3_t quo_o
);

  logic [5:0]  cnt_q;
  logic        done_q;
  logic [23:0] den_q;
  logic [2:0]  neg_q;
  logic [2:0][56:0] n_q, n_d;
  logic [2:0][23:0] r_q, r_d;
  logic [2:0][55:0] mag;
  logic [2:0][24:0] rs;

  // One restoring step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = num_i[i][55] ? 56'(-num_i[i]) : num_i[i];
      rs[i]  = {r_q[i], n_q[i][56]};
      if (rs[i] >= {1'b0, den_q}) begin
        r_d[i] = 24'(rs[i] - {1'b0, den_q});
        n_d[i] = {n_q[i][55:0], 1'b1};
      end else begin
        r_d[i] = rs[i][23:0];
        n_d[i] = {n_q[i][55:0], 1'b0};
      end
      quo_o[i] = neg_q[i] ? -{1'b0, n_q[i]} : {1'b0, n_q[i]};
    end
  end

  // Count the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 6'd1);
      if (start_i) begin
        cnt_q <= 6'd57;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // Load magnitudes plus half the divisor, then shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= num_i[i][55];
        n_q[i]   <= {1'b0, mag[i]} + 57'(den_i >> 1);
        r_q[i]   <= '0;
      end
    end else if (cnt_q != '0) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;

endmodule

/* hdl/linear_blend_skinning_unit.sv */
// ---------------------------------------------------------------------------
// linear_blend_skinning_unit
// Q16.16 linear blend skinning of vertices against stored bone matrices.
// ---------------------------------------------------------------------------
// Usage: write bone_enable_mask (byte 0) and recalc_normal (byte 8) over the
// APB port while idle. Load matrix words as kind 0 (bone) and kind 1 (pre or
// post) input words, one word per item. Each vertex is a position word, a
// normal word and its influence words, the last one flagged.
// Input words are taken one at a time: in_ready_o is high only while idle.
// A position and an enabled influence each run the matrix engine, which reads
// one matrix word per cycle from the stores and runs one multiplier.
// Closing a vertex with weight runs the divider, then the post matrix, then the
// normal matrix when recalc_normal is set, then loads the output register. A
// vertex without influences goes straight to the output register.
// The result word waits in the output register while the receiver stalls;
// the block goes on taking matrix, position and influence words meanwhile,
// and only the next result waits for the register to drain.
// Reset clears the vertex state and sets recalc_normal; the matrix stores
// hold no reset value and must be written before use.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_blend_skinning_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lbs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lbs_pkg::out_t out_data_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PRE  = 8'b0000_0010,
    S_INFL = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_POST = 8'b0010_0000,
    S_NORM = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [63:0] mask_q;
  logic        recalc_q;

  lbs_pkg::vec3_t local_q, norm_q, pre_co_q, pos_r_q, nrm_r_q;
  lbs_pkg::acc3_t acc_q;
  logic           nv_q;
  logic [23:0]    total_q;
  logic [16:0]    best_w_q, w_q;
  logic [5:0]     best_bone_q;
  logic           have_best_q, last_q;
  logic [1:0]     cnt_q, ptag_q, cidx;
  logic           pv_q;
  logic           close_q;
  logic signed [50:0] prod_q, prod_d;
  logic signed [32:0] diff;
  logic signed [56:0] asum;

  lbs_pkg::out_t out_q;
  logic          out_valid_q;

  lbs_pkg::mv_req_t mv_req;
  lbs_pkg::vec3_t   mv_vec, mv_res, in_vec, cvec;
  logic             mv_busy, mv_done;
  logic [lbs_pkg::BONE_AW-1:0] bone_raddr, bone_waddr;
  logic [lbs_pkg::PP_AW-1:0]   pp_raddr, pp_waddr;
  logic [31:0]      bone_rdata, pp_rdata;
  logic             bone_we, pp_we;

  logic           div_start, div_done;
  lbs_pkg::quo3_t div_quo;

  logic        acc_in, in_bone, infl_en, emit_go, out_free, cfg_we, clear_v;
  logic [16:0] wc;
  logic [24:0] tsum;
  logic signed [63:0] csum [3];

  // Input decode
  assign acc_in  = in_valid_i && in_ready_o;
  assign in_bone = {1'b0, in_data_i.slot} < 7'(lbs_pkg::BONES);
  assign wc      = (in_data_i.weight > lbs_pkg::WEIGHT_ONE) ? lbs_pkg::WEIGHT_ONE
                                                           : in_data_i.weight;
  assign infl_en = in_bone && mask_q[in_data_i.slot] && (wc != '0);
  assign in_vec  = {in_data_i.value_c, in_data_i.value_b, in_data_i.value_a};
  assign tsum    = {1'b0, total_q} + 25'(wc);
  assign emit_go = (acc_in && in_data_i.kind == lbs_pkg::KIND_INFL && !infl_en
                    && in_data_i.last) || close_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Store writes
  assign bone_we    = acc_in && in_data_i.kind == lbs_pkg::KIND_BONE && in_bone;
  assign bone_waddr = lbs_pkg::BONE_AW'({in_data_i.slot, in_data_i.word_index});
  assign pp_we      = acc_in && in_data_i.kind == lbs_pkg::KIND_PREPOST
                      && in_data_i.slot < 6'd2;
  assign pp_waddr   = {in_data_i.slot[0], in_data_i.word_index};

  // Corrected position from the quotient
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = $signed(pre_co_q[i]) + $signed(div_quo[i]);
      cvec[i] = lbs_pkg::sat32(csum[i]);
    end
  end

  // Weighted offset of one axis
  assign cidx   = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
  assign diff   = $signed(mv_res[cidx]) - $signed(pre_co_q[cidx]);
  assign prod_d = diff * $signed({1'b0, w_q});
  assign asum   = $signed(acc_q[ptag_q]) + $signed(prod_q);

  // Sequencer
  always_comb begin
    state_d          = state_q;
    mv_req           = '0;
    mv_vec           = pre_co_q;
    div_start        = 1'b0;
    clear_v          = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          case (in_data_i.kind)
            lbs_pkg::KIND_POS: begin
              mv_req.start     = 1'b1;
              mv_req.four_cols = 1'b1;
              mv_vec           = in_vec;
              clear_v          = 1'b1;
              state_d          = S_PRE;
            end
            lbs_pkg::KIND_NORM: begin
              if (in_data_i.last) begin
                clear_v = 1'b1;
                state_d = S_FIN;
              end
            end
            lbs_pkg::KIND_INFL: begin
              if (infl_en) begin
                mv_req.start     = 1'b1;
                mv_req.use_bone  = 1'b1;
                mv_req.four_cols = 1'b1;
                mv_req.slot      = in_data_i.slot;
                state_d          = S_INFL;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_PRE: begin
        if (mv_done) state_d = S_IDLE;
      end
      S_INFL: begin
        if (mv_done) state_d = S_ACC;
      end
      S_ACC: begin
        if (cnt_q == 2'd3) state_d = last_q ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          mv_req.start     = 1'b1;
          mv_req.four_cols = 1'b1;
          mv_req.slot      = 6'd1;
          mv_vec           = cvec;
          state_d          = S_POST;
        end
      end
      S_POST: begin
        if (mv_done) begin
          if (recalc_q && have_best_q) begin
            mv_req.start    = 1'b1;
            mv_req.use_bone = 1'b1;
            mv_req.slot     = best_bone_q;
            mv_vec          = norm_q;
            state_d         = S_NORM;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_NORM: begin
        if (mv_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          clear_v = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // Start closing the vertex
    if (emit_go) begin
      if (total_q != '0) begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end else begin
        state_d = S_FIN;
      end
    end
  end

  // Control state and vertex state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= '0;
      recalc_q    <= 1'b1;
      out_valid_q <= 1'b0;
      local_q     <= '0;
      norm_q      <= '0;
      pre_co_q    <= '0;
      acc_q       <= '0;
      total_q     <= '0;
      best_w_q    <= '0;
      best_bone_q <= '0;
      have_best_q <= 1'b0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      close_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      // Configuration writes
      if (cfg_we) begin
        if (paddr[3] == lbs_pkg::REG_MASK) begin
          mask_q <= pwdata;
        end else begin
          recalc_q <= pwdata[0];
        end
      end
      // Output register
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Vertex inputs
      if (acc_in && in_data_i.kind == lbs_pkg::KIND_POS) begin
        local_q <= in_vec;
      end
      if (acc_in && in_data_i.kind == lbs_pkg::KIND_NORM) begin
        norm_q <= in_vec;
      end
      if (state_q == S_PRE && mv_done) begin
        pre_co_q <= mv_res;
      end
      // Influence weights and strongest bone
      if (acc_in && in_data_i.kind == lbs_pkg::KIND_INFL && infl_en) begin
        total_q <= tsum[24] ? lbs_pkg::TOTAL_MAX : tsum[23:0];
        if (!have_best_q || wc > best_w_q) begin
          have_best_q <= 1'b1;
          best_w_q    <= wc;
          best_bone_q <= in_data_i.slot;
        end
      end
      // Accumulate one axis per cycle
      cnt_q <= (state_q == S_ACC) ? cnt_q + 2'd1 : 2'd0;
      pv_q  <= (state_q == S_ACC) && (cnt_q != 2'd3);
      if (pv_q) begin
        if (asum[56] != asum[55]) begin
          acc_q[ptag_q] <= {asum[56], {55{~asum[56]}}};
        end else begin
          acc_q[ptag_q] <= asum[55:0];
        end
      end
      // Close the vertex once the last axis has landed
      close_q <= (state_q == S_ACC) && (cnt_q == 2'd3) && last_q;
      // Drop the vertex accumulators
      if (clear_v) begin
        acc_q       <= '0;
        total_q     <= '0;
        best_w_q    <= '0;
        best_bone_q <= '0;
        have_best_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (acc_in && in_data_i.kind == lbs_pkg::KIND_INFL) begin
      w_q    <= wc;
      last_q <= in_data_i.last;
    end
    prod_q <= prod_d;
    ptag_q <= cidx;
    // Result held for the output register
    if (acc_in && in_data_i.kind == lbs_pkg::KIND_NORM) begin
      pos_r_q <= local_q;
      nrm_r_q <= in_vec;
      nv_q    <= 1'b0;
    end
    if (emit_go) begin
      pos_r_q <= local_q;
      nrm_r_q <= norm_q;
      nv_q    <= 1'b0;
    end
    if (state_q == S_POST && mv_done) begin
      pos_r_q <= mv_res;
    end
    if (state_q == S_NORM && mv_done) begin
      nrm_r_q <= mv_res;
      nv_q    <= 1'b1;
    end
    if (state_q == S_FIN && out_free) begin
      out_q.pos_x        <= pos_r_q[0];
      out_q.pos_y        <= pos_r_q[1];
      out_q.pos_z        <= pos_r_q[2];
      out_q.norm_x       <= nrm_r_q[0];
      out_q.norm_y       <= nrm_r_q[1];
      out_q.norm_z       <= nrm_r_q[2];
      out_q.normal_valid <= nv_q;
    end
  end

  // APB register port
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[3] == lbs_pkg::REG_RECALC) ? {63'd0, recalc_q} : mask_q;

  // Matrix stores
  lbs_ram #(.WIDTH(32), .DEPTH(lbs_pkg::BONES * 16)) u_bone_ram (
    .clk_i   (clk_i),
    .we_i    (bone_we),
    .waddr_i (bone_waddr),
    .wdata_i (in_data_i.value_a),
    .raddr_i (bone_raddr),
    .rdata_o (bone_rdata)
  );

  lbs_ram #(.WIDTH(32), .DEPTH(32)) u_pp_ram (
    .clk_i   (clk_i),
    .we_i    (pp_we),
    .waddr_i (pp_waddr),
    .wdata_i (in_data_i.value_a),
    .raddr_i (pp_raddr),
    .rdata_o (pp_rdata)
  );

  lbs_matvec u_matvec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (mv_req),
    .vec_i        (mv_vec),
    .bone_rdata_i (bone_rdata),
    .pp_rdata_i   (pp_rdata),
    .bone_raddr_o (bone_raddr),
    .pp_raddr_o   (pp_raddr),
    .busy_o       (mv_busy),
    .done_o       (mv_done),
    .res_o        (mv_res)
  );

  lbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (total_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `LBS_ASSERT(a_best_has_weight, clk_i, rst_ni, have_best_q |-> (total_q != '0))
  `LBS_ASSERT(a_mv_start_idle, clk_i, rst_ni, mv_req.start |-> !mv_busy)
  `LBS_ASSERT(a_out_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_FIN))
  `LBS_ASSERT_NEVER(a_no_done_idle, clk_i, rst_ni, mv_done && (state_q == S_IDLE))

endmodule
